FILE: rtl/bounding_box_diagonal_top_assert.svh
`ifndef BOUNDING_BOX_DIAGONAL_TOP_ASSERT_SVH
`define BOUNDING_BOX_DIAGONAL_TOP_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define BBD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define BBD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bbd_pkg.sv
package bbd_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FIFO_DEPTH      = 2;

    typedef enum logic [1:0] {
        BACK_IDLE,
        BACK_SQUARE,
        BACK_ROOT,
        BACK_OUT
    } back_state_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

FILE: rtl/bbd_stream_if.sv
interface bbd_point_if #(
    parameter int CW = 32
);
    logic          valid;
    logic          ready;
    logic [CW-1:0] coord_x;
    logic [CW-1:0] coord_y;
    logic [CW-1:0] coord_z;
    logic          last_point;

    modport source (output valid, output coord_x, output coord_y, output coord_z,
                    output last_point, input ready);
    modport sink   (input valid, input coord_x, input coord_y, input coord_z,
                    input last_point, output ready);
endinterface

interface bbd_diag_if #(
    parameter int DW = 33
);
    logic          valid;
    logic          ready;
    logic [DW-1:0] diagonal;

    modport source (output valid, output diagonal, input ready);
    modport sink   (input valid, input diagonal, output ready);
endinterface

FILE: rtl/bbd_front.sv
module bbd_front
    import bbd_pkg::*;
#(
    parameter int CW = COORD_WIDTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    bbd_point_if.sink       points,
    input  fifo_status_t    qstat,
    output logic            push,
    output logic [3*CW-1:0] push_data
);

    logic          set_open_reg;
    logic          set_open_next;
    logic [CW-1:0] min_reg [3];
    logic [CW-1:0] max_reg [3];
    logic [CW-1:0] min_next [3];
    logic [CW-1:0] max_next [3];
    logic [CW-1:0] biased [3];
    logic [CW-1:0] coord [3];
    logic          accept;

    assign coord[0] = points.coord_x;
    assign coord[1] = points.coord_y;
    assign coord[2] = points.coord_z;

    assign points.ready = !qstat.full;
    assign accept       = points.valid && points.ready;
    assign push         = accept && points.last_point;

    // Offset binary makes an unsigned compare follow the signed order.
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            biased[a] = {~coord[a][CW-1], coord[a][CW-2:0]};
            if (!set_open_reg)
            begin
                min_next[a] = biased[a];
                max_next[a] = biased[a];
            end
            else
            begin
                min_next[a] = (biased[a] < min_reg[a]) ? biased[a] : min_reg[a];
                max_next[a] = (biased[a] > max_reg[a]) ? biased[a] : max_reg[a];
            end
            push_data[a*CW +: CW] = max_next[a] - min_next[a];
        end
    end

    always_comb
    begin
        set_open_next = set_open_reg;
        if (accept)
        begin
            set_open_next = !points.last_point;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_open_reg <= 1'b0;
        end
        else
        begin
            set_open_reg <= set_open_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int a = 0; a < 3; a++)
            begin
                min_reg[a] <= min_next[a];
                max_reg[a] <= max_next[a];
            end
        end
    end

endmodule

FILE: rtl/bbd_span_fifo.sv
module bbd_span_fifo
    import bbd_pkg::*;
#(
    parameter int WIDTH = 3 * COORD_WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output fifo_status_t     qstat
);

    localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNW = $clog2(FIFO_DEPTH + 1);

    logic [WIDTH-1:0] mem [FIFO_DEPTH];
    logic [WIDTH-1:0] pop_data_reg;
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CNW-1:0]   count_reg;
    logic [CNW-1:0]   count_next;
    logic             do_push;
    logic             do_pop;

    assign qstat.full  = (count_reg == CNW'(FIFO_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign pop_data    = pop_data_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // The head entry is prefetched into a register, with the incoming item passed
    // straight through when it lands in the slot that is read next.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
        if (do_push && (wr_ptr_reg == rd_ptr_next))
        begin
            pop_data_reg <= push_data;
        end
        else
        begin
            pop_data_reg <= mem[rd_ptr_next];
        end
    end

endmodule

FILE: rtl/bbd_back.sv
module bbd_back
    import bbd_pkg::*;
#(
    parameter int CW = COORD_WIDTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  fifo_status_t    qstat,
    output logic            pop,
    input  logic [3*CW-1:0] pop_data,
    bbd_diag_if.source      results
);

    localparam int SW   = 2 * CW + 2;
    localparam int RW   = CW + 4;
    localparam int CNTW = $clog2(CW + 2);
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Z = 2'd2;

    back_state_t    state_reg;
    back_state_t    state_next;
    logic [CW-1:0]  span_reg [3];
    logic [1:0]     axis_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [SW-1:0]  sum_reg;
    logic [SW-1:0]  mcand_reg;
    logic [CW-1:0]  mplier_reg;
    logic [RW-1:0]  rem_reg;
    logic [CW:0]    root_reg;
    logic [RW-1:0]  rem_shift;
    logic [RW-1:0]  trial;
    logic           take_bit;
    logic           square_done;
    logic           root_done;

    assign square_done = (cnt_reg == CNTW'(CW - 1));
    assign root_done   = (cnt_reg == CNTW'(CW));

    // One root bit per step, two radicand bits brought down each step.
    assign rem_shift = {rem_reg[RW-3:0], sum_reg[SW-1 -: 2]};
    assign trial     = {{(RW - CW - 3){1'b0}}, root_reg, 2'b01};
    assign take_bit  = (rem_shift >= trial);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BACK_IDLE:
            begin
                if (!qstat.empty)
                begin
                    state_next = BACK_SQUARE;
                end
            end
            BACK_SQUARE:
            begin
                if (square_done && axis_reg == AXIS_Z)
                begin
                    state_next = BACK_ROOT;
                end
            end
            BACK_ROOT:
            begin
                if (root_done)
                begin
                    state_next = BACK_OUT;
                end
            end
            BACK_OUT:
            begin
                if (results.ready)
                begin
                    state_next = BACK_IDLE;
                end
            end
            default:
            begin
                state_next = BACK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop              = (state_reg == BACK_IDLE) && !qstat.empty;
        results.valid    = (state_reg == BACK_OUT);
        results.diagonal = root_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BACK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            BACK_IDLE:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    span_reg[a] <= pop_data[a*CW +: CW];
                end
                mcand_reg  <= SW'(pop_data[CW-1:0]);
                mplier_reg <= pop_data[CW-1:0];
                axis_reg   <= AXIS_X;
                cnt_reg    <= '0;
                sum_reg    <= '0;
            end
            BACK_SQUARE:
            begin
                sum_reg <= sum_reg + (mplier_reg[0] ? mcand_reg : '0);
                if (square_done)
                begin
                    cnt_reg <= '0;
                    rem_reg <= '0;
                    root_reg <= '0;
                    if (axis_reg != AXIS_Z)
                    begin
                        axis_reg   <= axis_reg + 1'b1;
                        mcand_reg  <= SW'(span_reg[axis_reg + 1'b1]);
                        mplier_reg <= span_reg[axis_reg + 1'b1];
                    end
                end
                else
                begin
                    cnt_reg    <= cnt_reg + 1'b1;
                    mcand_reg  <= {mcand_reg[SW-2:0], 1'b0};
                    mplier_reg <= {1'b0, mplier_reg[CW-1:1]};
                end
            end
            BACK_ROOT:
            begin
                cnt_reg  <= cnt_reg + 1'b1;
                sum_reg  <= {sum_reg[SW-3:0], 2'b00};
                rem_reg  <= take_bit ? rem_shift - trial : rem_shift;
                root_reg <= {root_reg[CW-1:0], take_bit};
            end
            default:
            begin
            end
        endcase
    end

endmodule

FILE: rtl/bounding_box_diagonal_top.sv
// Channel   Role    Payload
// points    sink    coord_x, coord_y, coord_z (signed), last_point
// results   source  diagonal (unsigned, COORD_WIDTH+1 bits)
//
// The front takes one point per cycle and keeps the per-axis extremes.
// Each finished set waits in a two-entry queue; the back then computes a
// bit-serial square per axis and a bit-per-step square root, and holds the
// result until the output handshake. Points stall only while the queue is full.
// Reset is asynchronous and clears the open set, the queue and the back.
module bounding_box_diagonal_top
    import bbd_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    bbd_point_if.sink  points,
    bbd_diag_if.source results
);

    fifo_status_t                 qstat;
    logic                         push;
    logic                         pop;
    logic [3*COORD_WIDTH-1:0]     push_data;
    logic [3*COORD_WIDTH-1:0]     pop_data;

    bbd_front #(
        .CW(COORD_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .points    (points),
        .qstat     (qstat),
        .push      (push),
        .push_data (push_data)
    );

    bbd_span_fifo #(
        .WIDTH(3 * COORD_WIDTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .qstat     (qstat)
    );

    bbd_back #(
        .CW(COORD_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .qstat    (qstat),
        .pop      (pop),
        .pop_data (pop_data),
        .results  (results)
    );

endmodule

FILE: rtl/bbd_checker.sv
`include "bounding_box_diagonal_top_assert.svh"

module bbd_checker
    import bbd_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 pt_valid,
    input logic                 pt_ready,
    input logic                 pt_last,
    input logic                 res_valid,
    input logic                 res_ready,
    input logic [COORD_WIDTH:0] res_diagonal
);

    localparam int PNW = $clog2(FIFO_DEPTH + 2);

    logic [PNW-1:0] pending_reg;
    logic [PNW-1:0] pending_next;
    logic           set_done;
    logic           res_taken;

    assign set_done  = pt_valid && pt_ready && pt_last;
    assign res_taken = res_valid && res_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (set_done && !res_taken)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (res_taken && !set_done)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `BBD_ASSERT_NEXT(a_result_holds, res_valid && !res_ready, res_valid && $stable(res_diagonal), "stalled result changed")
    `BBD_ASSERT_NOW(a_result_has_set, res_valid, pending_reg != '0, "result without a finished set")
    `BBD_ASSERT_NOW(a_pending_bounded, set_done, pending_reg < PNW'(FIFO_DEPTH + 1), "too many sets in flight")
    `BBD_ASSERT_NOW(a_ready_when_empty, pending_reg == '0, pt_ready, "points stalled with nothing in flight")

endmodule

bind bounding_box_diagonal_top bbd_checker #(
    .COORD_WIDTH(COORD_WIDTH)
) u_bbd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pt_valid     (points.valid),
    .pt_ready     (points.ready),
    .pt_last      (points.last_point),
    .res_valid    (results.valid),
    .res_ready    (results.ready),
    .res_diagonal (results.diagonal)
);

FILE: dv/tb.sv
module tb;
    import bbd_pkg::*;

    localparam int CW          = COORD_WIDTH_DEF;
    localparam int DW          = CW + 1;
    localparam int HOLD_CYCLES = 1500;
    localparam int SETTLE      = 4 * CW + 40;
    localparam int RAND_ITEMS  = 490;

    localparam logic [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] C_ONE = 32'sh0001_0000;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] z;
        logic          last;
        logic          typed;
        logic [DW-1:0] diag;
    } point_row_t;

    logic clk;
    logic rst_n;

    bbd_point_if #(.CW(CW)) pts ();
    bbd_diag_if  #(.DW(DW)) res ();

    bounding_box_diagonal_top #(.COORD_WIDTH(CW)) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .points  (pts),
        .results (res)
    );

    logic          row_typed;
    logic [DW-1:0] row_diag;

    logic [CW-1:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
    bit            box_open;
    logic [DW-1:0] pending_diags [$];
    int            fails;
    bit            hold_req;

    point_row_t directed_rows [20] = '{
        '{32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b1, 33'd0},
        '{C_MAX, C_MAX, C_MAX, 1'b1, 1'b1, 33'd0},
        '{C_MIN, C_MIN, C_MIN, 1'b1, 1'b1, 33'd0},
        '{C_MIN, C_MIN, C_MIN, 1'b0, 1'b0, 33'd0},
        '{C_MAX, C_MAX, C_MAX, 1'b1, 1'b1, 33'd7439101571},
        '{C_MIN, 32'sd0, 32'sd0, 1'b0, 1'b0, 33'd0},
        '{C_MAX, 32'sd0, 32'sd0, 1'b1, 1'b1, 33'd4294967295},
        '{32'sd0, C_MIN, 32'sd0, 1'b0, 1'b0, 33'd0},
        '{32'sd0, C_MAX, 32'sd0, 1'b1, 1'b1, 33'd4294967295},
        '{32'sd0, 32'sd0, C_MAX, 1'b0, 1'b0, 33'd0},
        '{32'sd0, 32'sd0, C_MIN, 1'b1, 1'b1, 33'd4294967295},
        '{32'sd0, 32'sd0, 32'sd0, 1'b0, 1'b0, 33'd0},
        '{3 * C_ONE, 4 * C_ONE, 32'sd0, 1'b1, 1'b1, 33'd327680},
        '{-C_ONE, 2 * C_ONE, -5 * C_ONE, 1'b0, 1'b0, 33'd0},
        '{7 * C_ONE, -3 * C_ONE, C_ONE, 1'b0, 1'b0, 33'd0},
        '{32'sd0, 32'sd0, 32'sd0, 1'b0, 1'b0, 33'd0},
        '{-2 * C_ONE, 5 * C_ONE, 9 * C_ONE, 1'b1, 1'b0, 33'd0},
        '{-32'sd1, -32'sd1, -32'sd1, 1'b0, 1'b0, 33'd0},
        '{-32'sd100, -32'sd7, -C_ONE, 1'b1, 1'b0, 33'd0},
        '{32'sd1, 32'sd1, 32'sd1, 1'b1, 1'b1, 33'd0}
    };

    always #5 clk = ~clk;

    initial
    begin
        #5000000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [DW-1:0] floor_sqrt(input logic [127:0] n);
        logic [63:0]  r;
        logic [63:0]  c;
        logic [127:0] sq;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            c  = r | (64'd1 << i);
            sq = 128'(c) * 128'(c);
            if (sq <= n)
                r = c;
        end
        return r[DW-1:0];
    endfunction

    function automatic logic [127:0] span_square(input logic [CW-1:0] lo, input logic [CW-1:0] hi);
        logic [CW-1:0] d;
        d = hi - lo;
        return 128'(d) * 128'(d);
    endfunction

    task automatic fold_point(input logic [CW-1:0] x, input logic [CW-1:0] y,
                              input logic [CW-1:0] z, input logic last,
                              output bit got, output logic [DW-1:0] diag);
        logic [CW-1:0] bx, by, bz;
        bx = {~x[CW-1], x[CW-2:0]};
        by = {~y[CW-1], y[CW-2:0]};
        bz = {~z[CW-1], z[CW-2:0]};
        if (!box_open)
        begin
            lo_x = bx; hi_x = bx;
            lo_y = by; hi_y = by;
            lo_z = bz; hi_z = bz;
            box_open = 1'b1;
        end
        else
        begin
            if (bx < lo_x) lo_x = bx;
            if (bx > hi_x) hi_x = bx;
            if (by < lo_y) lo_y = by;
            if (by > hi_y) hi_y = by;
            if (bz < lo_z) lo_z = bz;
            if (bz > hi_z) hi_z = bz;
        end
        got  = last;
        diag = '0;
        if (last)
        begin
            diag = floor_sqrt(span_square(lo_x, hi_x) + span_square(lo_y, hi_y)
                              + span_square(lo_z, hi_z));
            box_open = 1'b0;
        end
    endtask

    always @(posedge clk)
    begin : watch
        bit            got;
        logic [DW-1:0] diag;
        logic [DW-1:0] want;
        if (rst_n)
        begin
            if (res.valid && res.ready)
            begin
                if (pending_diags.size() == 0)
                begin
                    $error("diagonal: expected nothing, actual %0d", res.diagonal);
                    fails++;
                end
                else
                begin
                    want = pending_diags.pop_front();
                    if (res.diagonal !== want)
                    begin
                        $error("diagonal: expected %0d, actual %0d", want, res.diagonal);
                        fails++;
                    end
                end
            end
            if (pts.valid && pts.ready)
            begin
                fold_point(pts.coord_x, pts.coord_y, pts.coord_z, pts.last_point, got, diag);
                if (got)
                    pending_diags.push_back(row_typed ? row_diag : diag);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [CW-1:0] pick_coord(input logic [CW-1:0] base);
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return $urandom;
        if (r < 60)
            return base + CW'($urandom_range(0, 4000)) - CW'(2000);
        if (r < 75)
            return CW'($urandom_range(0, 2000)) - CW'(1000);
        case ($urandom_range(0, 4))
            0: return C_MIN;
            1: return C_MAX;
            2: return '0;
            3: return '1;
            default: return CW'(1);
        endcase
    endfunction

    initial
    begin
        int run;
        int gap;
        res.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                res.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            res.ready <= 1'b1;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 8);
            repeat (run) @(posedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                res.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    task automatic offer_point(input logic [CW-1:0] x, input logic [CW-1:0] y,
                               input logic [CW-1:0] z, input logic last,
                               input logic typed, input logic [DW-1:0] diag);
        pts.valid      <= 1'b1;
        pts.coord_x    <= x;
        pts.coord_y    <= y;
        pts.coord_z    <= z;
        pts.last_point <= last;
        row_typed      <= typed;
        row_diag       <= diag;
        @(posedge clk);
        while (!pts.ready)
            @(posedge clk);
    endtask

    task automatic idle_points(input int n);
        if (n > 0)
        begin
            pts.valid      <= 1'b0;
            pts.coord_x    <= $urandom;
            pts.coord_y    <= $urandom;
            pts.coord_z    <= $urandom;
            pts.last_point <= $urandom_range(0, 1);
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        @(posedge clk);
        while (pending_diags.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_sets(input int count, input bit crowd);
        int            left;
        int            r;
        int            quiet;
        logic [CW-1:0] bx, by, bz;
        left  = 0;
        quiet = 0;
        bx    = '0;
        by    = '0;
        bz    = '0;
        for (int n = 0; n < count || left != 0; n++)
        begin
            if (left == 0)
            begin
                r = $urandom_range(0, 99);
                if (crowd || r < 30)
                    left = $urandom_range(1, 2);
                else if (r < 85)
                    left = $urandom_range(3, 8);
                else
                    left = $urandom_range(9, 40);
                bx = $urandom;
                by = $urandom;
                bz = $urandom;
            end
            left--;
            offer_point(pick_coord(bx), pick_coord(by), pick_coord(bz),
                        left == 0, 1'b0, '0);
            if (quiet > 0)
                quiet--;
            else if ($urandom_range(0, 29) == 0)
                quiet = $urandom_range(20, 80);
            if (!crowd && quiet == 0)
                idle_points(pick_gap());
        end
        idle_points(1);
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n         <= 1'b0;
        pts.valid     <= 1'b0;
        pts.coord_x   <= '0;
        pts.coord_y   <= '0;
        pts.coord_z   <= '0;
        pts.last_point <= 1'b0;
        row_typed     <= 1'b0;
        row_diag      <= '0;
        box_open       = 1'b0;
        fails          = 0;
        hold_req       = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            offer_point(directed_rows[i].x, directed_rows[i].y, directed_rows[i].z,
                        directed_rows[i].last, directed_rows[i].typed, directed_rows[i].diag);
            idle_points(pick_gap());
        end
        idle_points(1);
        drain_results();

        random_sets(RAND_ITEMS / 2, 1'b0);

        hold_req = 1'b1;
        random_sets(40, 1'b1);
        drain_results();

        random_sets(RAND_ITEMS / 2, 1'b0);

        drain_results();
        repeat (SETTLE) @(posedge clk);
        if (fails == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/bbd_pkg.sv
rtl/bbd_stream_if.sv
rtl/bbd_front.sv
rtl/bbd_span_fifo.sv
rtl/bbd_back.sv
rtl/bounding_box_diagonal_top.sv
rtl/bbd_checker.sv
dv/tb.sv
